/* rtl/core/crnb_pkg.sv */
package crnb_pkg;

   localparam int MAX_SIDE = 64;
   localparam int SIDE_W   = $clog2(MAX_SIDE);
   localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int FIELD_W  = 6;
   localparam int PIX_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int STEP_W   = 24;
   localparam int SIZE_W   = 7;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   typedef enum logic [2:0] {
      REG_MODE,
      REG_BOX_SIZE,
      REG_SCALE_STEP,
      REG_IN_WIDTH,
      REG_IN_HEIGHT
   } reg_index_type;

   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_SAMPLE   = 1'b1;
   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   localparam logic              MODE_RESET   = MODE_BILINEAR;
   localparam logic [SIZE_W-1:0] BOX_RESET    = SIZE_W'(32);
   localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(65536);
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(64);

endpackage

/* rtl/core/crnb_if.sv */
interface crnb_req_if import crnb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [FIELD_W-1:0] row;
   logic [FIELD_W-1:0] col;
   logic [PIX_W-1:0]   pixel_in;

   modport source (output valid, kind, row, col, pixel_in, input ready);
   modport sink (input valid, kind, row, col, pixel_in, output ready);
endinterface

interface crnb_rsp_if import crnb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_out;
   logic [FIELD_W-1:0] out_row;
   logic [FIELD_W-1:0] out_col;

   modport source (output valid, pixel_out, out_row, out_col, input ready);
   modport sink (input valid, pixel_out, out_row, out_col, output ready);
endinterface

/* rtl/core/crop_resize_nn_bilinear_unit.sv */
// load item: written to the frame memory at the accepting edge (items enter in IDLE)
// sample item, nearest mode: MUL_R, MUL_C, one read in RD, RD_WAIT, then FIN
// sample item, bilinear mode: as above with four reads in RD and BLEND before FIN
// rate is set by the shared 6x24 multiplier (row, then column), the single frame
// memory port (one pixel read a cycle) and the shared channel blend unit (9 blends)
// reset is synchronous: CSR and control registers take defaults, frame memory is kept
module crop_resize_nn_bilinear_unit import crnb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   crnb_req_if.sink          req_if,
   crnb_rsp_if.source        rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int PROD_W     = FIELD_W + STEP_W;
   localparam int INT_W      = PROD_W - 16;
   localparam int COORD_W    = INT_W + 3;
   localparam int WRAP_STEPS = ((1 << FIELD_W) + MAX_SIDE - 1) / MAX_SIDE;

   typedef enum logic [2:0] {
      IDLE,
      MUL_R,
      MUL_C,
      RD,
      RD_WAIT,
      BLEND,
      FIN
   } state_type;

   typedef enum logic [1:0] {
      BL_ROW0,
      BL_ROW1,
      BL_COL
   } blend_step_type;

   // configuration
   logic              mode_ff;
   logic [SIZE_W-1:0] box_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   state_type          state_ff;
   blend_step_type     bstep_ff;
   logic [1:0]         ch_ff;
   logic [1:0]         rd_cnt_ff;
   logic [FIELD_W-1:0] row_ff;
   logic [FIELD_W-1:0] col_ff;
   logic [COORD_W-1:0] rbase_ff;
   logic [COORD_W-1:0] cbase_ff;
   logic [CHAN_W-1:0]  rfrac_ff;
   logic [CHAN_W-1:0]  cfrac_ff;
   logic [PIX_W-1:0]   px_ff [4];
   logic [CHAN_W-1:0]  a_ff;
   logic [CHAN_W-1:0]  b_ff;
   logic [PIX_W-1:0]   res_ff;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   pixel_out_ff;
   logic [FIELD_W-1:0] out_row_ff;
   logic [FIELD_W-1:0] out_col_ff;

   logic [PIX_W-1:0]   mem [MAX_SIDE * MAX_SIDE];
   logic [PIX_W-1:0]   rdata_ff;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;

   logic               req_acc;
   logic               csr_wr;
   logic [FIELD_W-1:0] mul_a;
   logic [PROD_W-1:0]  prod;
   logic [COORD_W-1:0] offset;
   logic [COORD_W-1:0] pos_base;
   logic [SIDE_W-1:0]  hi_r;
   logic [SIDE_W-1:0]  hi_c;
   logic [SIDE_W-1:0]  rd_r;
   logic [SIDE_W-1:0]  rd_c;
   logic [SIDE_W-1:0]  ld_r;
   logic [SIDE_W-1:0]  ld_c;
   logic [1:0]         rd_last;
   logic [CHAN_W-1:0]  bl_a;
   logic [CHAN_W-1:0]  bl_b;
   logic [CHAN_W-1:0]  bl_f;
   logic [16:0]        bl_sum;
   logic [CHAN_W-1:0]  bl_out;

   function automatic logic [SIDE_W-1:0] wrap_side(logic [FIELD_W-1:0] v);
      int t;
      t = int'(v);
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (t >= MAX_SIDE) begin
            t = t - MAX_SIDE;
         end
      end
      return SIDE_W'(t);
   endfunction

   function automatic logic [SIDE_W-1:0] side_hi(logic [SIZE_W-1:0] ext);
      int e;
      e = int'(ext);
      if (e == 0) begin
         e = 1;
      end
      if (e > MAX_SIDE) begin
         e = MAX_SIDE;
      end
      return SIDE_W'(e - 1);
   endfunction

   // top bit of a coordinate is its sign
   function automatic logic [SIDE_W-1:0] clamp_coord(logic [COORD_W-1:0] v,
                                                     logic [SIDE_W-1:0] hi);
      if (v[COORD_W-1]) begin
         return '0;
      end else if (v[COORD_W-2:0] > (COORD_W-1)'(hi)) begin
         return hi;
      end
      return v[SIDE_W-1:0];
   endfunction

   assign req_acc       = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pixel_out = pixel_out_ff;
   assign rsp_if.out_row   = out_row_ff;
   assign rsp_if.out_col   = out_col_ff;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         box_ff    <= BOX_RESET;
         step_ff   <= STEP_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_MODE:       mode_ff   <= csr_pwdata[0];
            REG_BOX_SIZE:   box_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_SCALE_STEP: step_ff   <= csr_pwdata[STEP_W-1:0];
            REG_IN_WIDTH:   width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_IN_HEIGHT:  height_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_MODE:       csr_prdata = CSR_DW'(mode_ff);
         REG_BOX_SIZE:   csr_prdata = CSR_DW'(box_ff);
         REG_SCALE_STEP: csr_prdata = CSR_DW'(step_ff);
         REG_IN_WIDTH:   csr_prdata = CSR_DW'(width_ff);
         REG_IN_HEIGHT:  csr_prdata = CSR_DW'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // shared multiplier: row position, then column position
   assign mul_a  = (state_ff == MUL_R) ? row_ff : col_ff;
   assign prod   = PROD_W'(mul_a) * PROD_W'(step_ff);
   assign offset = COORD_W'(height_ff[SIZE_W-1:1]) - COORD_W'(box_ff[SIZE_W-1:1]);
   assign pos_base = offset + COORD_W'(prod[PROD_W-1:16]);

   // neighbour address, clamped at the image edge
   assign hi_r    = side_hi(height_ff);
   assign hi_c    = side_hi(width_ff);
   assign rd_r    = clamp_coord(rbase_ff + COORD_W'(rd_cnt_ff[0]), hi_r);
   assign rd_c    = clamp_coord(cbase_ff + COORD_W'(rd_cnt_ff[1]), hi_c);
   assign ld_r    = wrap_side(req_if.row);
   assign ld_c    = wrap_side(req_if.col);
   assign rd_last = (mode_ff == MODE_BILINEAR) ? 2'd3 : 2'd0;

   assign mem_we   = req_acc && (req_if.kind == KIND_LOAD);
   assign mem_addr = (state_ff == IDLE)
                   ? ADDR_W'(ld_r) * ADDR_W'(MAX_SIDE) + ADDR_W'(ld_c)
                   : ADDR_W'(rd_r) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_c);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_if.pixel_in;
      end
      rdata_ff <= mem[mem_addr];
   end

   // shared channel blend unit
   always_comb begin
      case (bstep_ff)
         BL_ROW0: begin
            bl_a = px_ff[0][CHAN_W*ch_ff +: CHAN_W];
            bl_b = px_ff[1][CHAN_W*ch_ff +: CHAN_W];
            bl_f = rfrac_ff;
         end
         BL_ROW1: begin
            bl_a = px_ff[2][CHAN_W*ch_ff +: CHAN_W];
            bl_b = px_ff[3][CHAN_W*ch_ff +: CHAN_W];
            bl_f = rfrac_ff;
         end
         BL_COL: begin
            bl_a = a_ff;
            bl_b = b_ff;
            bl_f = cfrac_ff;
         end
         default: begin
            bl_a = a_ff;
            bl_b = b_ff;
            bl_f = cfrac_ff;
         end
      endcase
      bl_sum = 17'(bl_a) * 17'(9'd256 - {1'b0, bl_f}) + 17'(bl_b) * 17'(bl_f);
      bl_out = bl_sum[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= '0;
         ch_ff        <= '0;
         bstep_ff     <= BL_ROW0;
      end else begin
         // the finish step refills the output itself
         if (rsp_valid_ff && rsp_if.ready && state_ff != FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_acc) begin
                  row_ff <= req_if.row;
                  col_ff <= req_if.col;
                  if (req_if.kind == KIND_SAMPLE) begin
                     state_ff <= MUL_R;
                  end
               end
            end
            MUL_R: begin
               rbase_ff <= pos_base + COORD_W'(1);
               rfrac_ff <= prod[15:8];
               state_ff <= MUL_C;
            end
            MUL_C: begin
               // bilinear takes the column without the +1
               cbase_ff  <= pos_base + COORD_W'(mode_ff == MODE_NEAREST);
               cfrac_ff  <= prod[15:8];
               rd_cnt_ff <= '0;
               state_ff  <= RD;
            end
            RD: begin
               if (rd_cnt_ff != 2'd0) begin
                  px_ff[rd_cnt_ff - 2'd1] <= rdata_ff;
               end
               if (rd_cnt_ff == rd_last) begin
                  state_ff <= RD_WAIT;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 2'd1;
               end
            end
            RD_WAIT: begin
               px_ff[rd_cnt_ff] <= rdata_ff;
               if (mode_ff == MODE_NEAREST) begin
                  res_ff   <= rdata_ff;
                  state_ff <= FIN;
               end else begin
                  ch_ff    <= '0;
                  bstep_ff <= BL_ROW0;
                  state_ff <= BLEND;
               end
            end
            BLEND: begin
               case (bstep_ff)
                  BL_ROW0: begin
                     a_ff     <= bl_out;
                     bstep_ff <= BL_ROW1;
                  end
                  BL_ROW1: begin
                     b_ff     <= bl_out;
                     bstep_ff <= BL_COL;
                  end
                  default: begin
                     res_ff[CHAN_W*ch_ff +: CHAN_W] <= bl_out;
                     bstep_ff <= BL_ROW0;
                     if (ch_ff == 2'd2) begin
                        state_ff <= FIN;
                     end else begin
                        ch_ff <= ch_ff + 2'd1;
                     end
                  end
               endcase
            end
            FIN: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  pixel_out_ff <= res_ff;
                  out_row_ff   <= row_ff;
                  out_col_ff   <= col_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FIN))
      else $error("result raised outside the finish step");

   a_echo_match: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (out_row_ff == row_ff && out_col_ff == col_ff))
      else $error("result echo does not match the sampled item");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_if.kind == KIND_SAMPLE |=> state_ff == MUL_R)
      else $error("sample item did not start the sequencer");

   a_nearest_one_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == RD && mode_ff == MODE_NEAREST |-> rd_cnt_ff == 2'd0)
      else $error("nearest mode issued more than one read");

endmodule
